// ===== hdl/rrf_pkg.sv =====
package rrf_pkg;

    localparam int ARCH_REGS = 32;
    localparam int PHYS_REGS = 64;

    typedef enum logic [1:0] {
        ACT_RENAME = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_CREDIT = 2'd3
    } t_action;

    localparam logic [2:0] STALL_NONE   = 3'd0;
    localparam logic [2:0] STALL_CREDIT = 3'd1;
    localparam logic [2:0] STALL_LOAD   = 3'd2;
    localparam logic [2:0] STALL_STORE  = 3'd3;
    localparam logic [2:0] STALL_FREE   = 3'd4;

    localparam logic [1:0] CK_DISPATCH = 2'd0;
    localparam logic [1:0] CK_ROB      = 2'd1;
    localparam logic [1:0] CK_LOAD     = 2'd2;
    localparam logic [1:0] CK_STORE    = 2'd3;

    localparam logic [1:0] UK_LOAD  = 2'd1;
    localparam logic [1:0] UK_STORE = 2'd2;

    localparam logic [7:0] CREDIT_MAX = 8'd255;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] src1_arch;
        logic [4:0] src2_arch;
        logic [4:0] dest_arch;
        logic       dest_valid;
        logic [1:0] unit_kind;
        logic [5:0] commit_new_phys;
        logic [5:0] commit_old_phys;
        logic [1:0] credit_kind;
        logic [6:0] credit_amount;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic [5:0] src1_phys;
        logic [5:0] src2_phys;
        logic [5:0] dest_phys;
        logic [5:0] old_phys;
        logic       to_memory_unit;
        logic [2:0] stall_cause;
    } t_out;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RN_CHK,
        S_RN_SRC2,
        S_RN_DEST,
        S_RN_FIN,
        S_COMMIT,
        S_CREDIT,
        S_FL_RD,
        S_FL_WR,
        S_FL_FIN
    } t_state;

    typedef struct packed {
        logic latch;
        logic init_wr;
        logic rn_chk;
        logic rn_src2;
        logic rn_dest;
        logic rn_fin;
        logic commit;
        logic credit;
        logic fl_wr;
        logic fl_fin;
    } t_cmd;

    typedef struct packed {
        t_action in_action;
        logic    stall;
        logic    init_last;
        logic    fl_last;
    } t_status;

endpackage

// ===== hdl/rrf_ram.sv =====
module rrf_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rrf_ctrl.sv =====
module rrf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  rrf_pkg::t_status i_st,
    output rrf_pkg::t_cmd    o_cmd
);
    import rrf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:    if (i_st.init_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    case (i_st.in_action)
                        ACT_RENAME: n_state = S_RN_CHK;
                        ACT_COMMIT: n_state = S_COMMIT;
                        ACT_FLUSH:  n_state = S_FL_RD;
                        ACT_CREDIT: n_state = S_CREDIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RN_CHK:  n_state = i_st.stall ? S_IDLE : S_RN_SRC2;
            S_RN_SRC2: n_state = S_RN_DEST;
            S_RN_DEST: n_state = S_RN_FIN;
            S_RN_FIN:  n_state = S_IDLE;
            S_COMMIT:  n_state = S_IDLE;
            S_CREDIT:  n_state = S_IDLE;
            S_FL_RD:   n_state = S_FL_WR;
            S_FL_WR:   n_state = i_st.fl_last ? S_FL_FIN : S_FL_RD;
            S_FL_FIN:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_INIT:    o_cmd.init_wr = 1'b1;
            S_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            S_RN_CHK:  o_cmd.rn_chk  = 1'b1;
            S_RN_SRC2: o_cmd.rn_src2 = 1'b1;
            S_RN_DEST: o_cmd.rn_dest = 1'b1;
            S_RN_FIN:  o_cmd.rn_fin  = 1'b1;
            S_COMMIT:  o_cmd.commit  = 1'b1;
            S_CREDIT:  o_cmd.credit  = 1'b1;
            S_FL_RD:   o_cmd        = '0;
            S_FL_WR:   o_cmd.fl_wr   = 1'b1;
            S_FL_FIN:  o_cmd.fl_fin  = 1'b1;
            default:   o_cmd        = '0;
        endcase
    end

endmodule

// ===== hdl/rrf_dp.sv =====
module rrf_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rrf_pkg::t_cmd    i_cmd,
    output rrf_pkg::t_status o_st,
    input  rrf_pkg::t_in     i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    output rrf_pkg::t_out    o_result,
    output logic             o_strobe
);
    import rrf_pkg::*;

    localparam int AW   = $clog2(ARCH_REGS);
    localparam int PW   = $clog2(PHYS_REGS);
    localparam int MAXD = (ARCH_REGS > PHYS_REGS) ? ARCH_REGS : PHYS_REGS;
    localparam int CW   = $clog2(MAXD);

    // A ring pointer counts modulo twice the ring depth: a lap bit above the entry index.
    typedef struct packed {
        logic          wrap;
        logic [PW-1:0] idx;
    } t_ptr;

    function automatic t_ptr ptr_inc(t_ptr p);
        t_ptr q;
        q = p;
        if (p.idx == PW'(PHYS_REGS - 1)) begin
            q.idx  = '0;
            q.wrap = ~p.wrap;
        end else begin
            q.idx = p.idx + 1'b1;
        end
        return q;
    endfunction

    // True when the distance from one pointer to the other is below the ring depth.
    function automatic logic dist_lt(t_ptr from_p, t_ptr to_p);
        return (from_p.wrap == to_p.wrap) ? (to_p.idx >= from_p.idx) : (to_p.idx < from_p.idx);
    endfunction

    function automatic logic arch_ok(logic [4:0] a);
        return int'(a) < ARCH_REGS;
    endfunction

    logic          r_perfect;
    logic [7:0]    r_cred [4];
    t_ptr          r_sh;
    t_ptr          r_ch;
    t_ptr          r_tail;
    logic [CW-1:0] r_cnt;
    logic          r_strobe;
    t_in           r_item;
    t_out          r_res;
    logic [5:0]    r_s1;
    logic [5:0]    r_s2;

    logic [2:0]    cause;
    logic          stall;
    logic          is_load;
    logic          is_store;
    t_ptr          n_ch;
    logic          ret;
    logic          emit;
    t_out          n_res;
    logic [8:0]    cred_sum;
    logic [7:0]    cred_sat;

    logic          sp_we;
    logic [AW-1:0] sp_waddr;
    logic [5:0]    sp_wdata;
    logic [AW-1:0] sp_raddr;
    logic [5:0]    sp_rdata;
    logic          cm_we;
    logic [AW-1:0] cm_waddr;
    logic [5:0]    cm_wdata;
    logic [5:0]    cm_rdata;
    logic          rg_we;
    logic [PW-1:0] rg_waddr;
    logic [5:0]    rg_wdata;
    logic [5:0]    rg_rdata;

    assign is_load  = (r_item.unit_kind == UK_LOAD);
    assign is_store = (r_item.unit_kind == UK_STORE);

    always_comb begin
        cause = STALL_NONE;
        if (r_cred[CK_DISPATCH] == '0 || r_cred[CK_ROB] == '0) begin
            cause = STALL_CREDIT;
        end else if (!r_perfect && is_load && r_cred[CK_LOAD] == '0) begin
            cause = STALL_LOAD;
        end else if (!r_perfect && is_store && r_cred[CK_STORE] == '0) begin
            cause = STALL_STORE;
        end else if (r_item.dest_valid && r_sh == r_tail) begin
            cause = STALL_FREE;
        end
    end

    assign stall = (cause != STALL_NONE);

    // The committed head moves first; the room check for the returned register uses it.
    assign n_ch = (r_item.commit_new_phys != '0 && r_ch != r_sh) ? ptr_inc(r_ch) : r_ch;
    assign ret  = (r_item.commit_old_phys != '0) && dist_lt(n_ch, r_tail);

    assign cred_sum = {1'b0, r_cred[r_item.credit_kind]} + {2'b0, r_item.credit_amount};
    assign cred_sat = (cred_sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : cred_sum[7:0];

    assign emit = i_cmd.commit | i_cmd.credit | i_cmd.fl_fin | i_cmd.rn_fin
                | (i_cmd.rn_chk & stall);

    always_comb begin
        n_res = '0;
        if (i_cmd.rn_chk) begin
            n_res.stall_cause = cause;
        end
        if (i_cmd.rn_fin) begin
            n_res.accepted       = 1'b1;
            n_res.src1_phys      = r_s1;
            n_res.src2_phys      = r_s2;
            n_res.dest_phys      = r_item.dest_valid ? rg_rdata : '0;
            n_res.old_phys       = (r_item.dest_valid && arch_ok(r_item.dest_arch))
                                   ? sp_rdata : '0;
            n_res.to_memory_unit = !r_perfect && (is_load || is_store);
        end
    end

    always_comb begin
        sp_we    = 1'b0;
        sp_waddr = AW'(r_cnt);
        sp_wdata = '0;
        if (i_cmd.init_wr) begin
            sp_we = int'(r_cnt) < ARCH_REGS;
        end else if (i_cmd.fl_wr) begin
            sp_we    = 1'b1;
            sp_wdata = cm_rdata;
        end else if (i_cmd.rn_fin) begin
            sp_we    = r_item.dest_valid && arch_ok(r_item.dest_arch);
            sp_waddr = AW'(r_item.dest_arch);
            sp_wdata = rg_rdata;
        end
    end

    always_comb begin
        sp_raddr = AW'(r_item.src1_arch);
        if (i_cmd.rn_src2) begin
            sp_raddr = AW'(r_item.src2_arch);
        end else if (i_cmd.rn_dest) begin
            sp_raddr = AW'(r_item.dest_arch);
        end
    end

    always_comb begin
        cm_we    = 1'b0;
        cm_waddr = AW'(r_cnt);
        cm_wdata = '0;
        if (i_cmd.init_wr) begin
            cm_we = int'(r_cnt) < ARCH_REGS;
        end else if (i_cmd.commit) begin
            cm_we    = r_item.commit_new_phys != '0 && arch_ok(r_item.dest_arch);
            cm_waddr = AW'(r_item.dest_arch);
            cm_wdata = r_item.commit_new_phys;
        end
    end

    always_comb begin
        rg_we    = 1'b0;
        rg_waddr = PW'(r_cnt);
        rg_wdata = '0;
        if (i_cmd.init_wr) begin
            rg_we    = int'(r_cnt) < PHYS_REGS;
            rg_wdata = (int'(r_cnt) < PHYS_REGS - 1) ? 6'(r_cnt + 1'b1) : 6'd0;
        end else if (i_cmd.commit) begin
            rg_we    = ret;
            rg_waddr = r_tail.idx;
            rg_wdata = r_item.commit_old_phys;
        end
    end

    rrf_ram #(.WIDTH(6), .DEPTH(ARCH_REGS)) u_spec_map (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_raddr (sp_raddr),
        .o_rdata (sp_rdata)
    );

    rrf_ram #(.WIDTH(6), .DEPTH(ARCH_REGS)) u_cmt_map (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_raddr (AW'(r_cnt)),
        .o_rdata (cm_rdata)
    );

    rrf_ram #(.WIDTH(6), .DEPTH(PHYS_REGS)) u_free_ring (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata (rg_wdata),
        .i_raddr (r_sh.idx),
        .o_rdata (rg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perfect  <= 1'b0;
            r_cred     <= '{default: '0};
            r_sh       <= '0;
            r_ch       <= '0;
            r_tail     <= '{wrap: 1'b0, idx: PW'(PHYS_REGS - 1)};
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= emit;
            if (i_cfg_we) begin
                r_perfect <= i_cfg_wdata;
            end
            if (i_cmd.latch) begin
                r_cnt <= '0;
            end else if (i_cmd.init_wr || i_cmd.fl_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.rn_fin) begin
                if (r_item.dest_valid) begin
                    r_sh <= ptr_inc(r_sh);
                end
                r_cred[CK_DISPATCH] <= r_cred[CK_DISPATCH] - 1'b1;
                r_cred[CK_ROB]      <= r_cred[CK_ROB] - 1'b1;
                if (!r_perfect && is_load) begin
                    r_cred[CK_LOAD] <= r_cred[CK_LOAD] - 1'b1;
                end else if (!r_perfect && is_store) begin
                    r_cred[CK_STORE] <= r_cred[CK_STORE] - 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_ch <= n_ch;
                if (ret) begin
                    r_tail <= ptr_inc(r_tail);
                end
            end
            if (i_cmd.credit) begin
                r_cred[r_item.credit_kind] <= cred_sat;
            end
            if (i_cmd.fl_fin) begin
                r_sh   <= r_ch;
                r_cred <= '{default: '0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.rn_src2) begin
            r_s1 <= arch_ok(r_item.src1_arch) ? sp_rdata : '0;
        end
        if (i_cmd.rn_dest) begin
            r_s2 <= arch_ok(r_item.src2_arch) ? sp_rdata : '0;
        end
        if (emit) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

    assign o_st.in_action = t_action'(i_item.action);
    assign o_st.stall     = stall;
    assign o_st.init_last = (r_cnt == CW'(MAXD - 1));
    assign o_st.fl_last   = (r_cnt == CW'(ARCH_REGS - 1));

`ifndef ASSERT_OFF
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.accepted) |-> (r_res.stall_cause == STALL_NONE))
        else $error("accepted rename carries a stall cause");

    a_credit_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rn_fin |-> (r_cred[CK_DISPATCH] != '0 && r_cred[CK_ROB] != '0))
        else $error("rename completed without dispatch or reorder credit");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rn_fin && r_item.dest_valid) |-> (r_sh != r_tail))
        else $error("register taken from an empty free ring");
`endif

endmodule

// ===== hdl/register_rename_free_list.sv =====
// Channel   Ports                         Transfer
// input     start, busy, i_item           edge with start high and busy low
// result    o_strobe, o_result            one cycle per item, o_strobe high
// config    i_cfg_we, i_cfg_wdata         edge with i_cfg_we high
//
// A rename is busy in S_RN_CHK, S_RN_SRC2, S_RN_DEST and S_RN_FIN (S_RN_CHK alone if
// it stalls): its three mapping reads share the single read port of the speculative map
// memory. Commit and credit use S_COMMIT or S_CREDIT alone. A flush copies the committed
// map entry by entry (S_FL_RD, S_FL_WR), then S_FL_FIN. After reset a clearing pass loads
// the maps and ring. Each item gives one result as busy falls; the receiver cannot stall it.
module register_rename_free_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rrf_pkg::t_in  i_item,
    output rrf_pkg::t_out o_result,
    output logic          o_strobe,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import rrf_pkg::*;

    t_cmd    cmd;
    t_status st;

    rrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    rrf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule

// ===== tb/tb_register_rename_free_list.sv =====
`timescale 1ns / 1ps

module tb_register_rename_free_list;
    import rrf_pkg::*;

    typedef struct {
        logic [4:0] arch;
        logic [5:0] new_phys;
        logic [5:0] old_phys;
    } t_renamed;

    class rename_scoreboard;
        t_out       expected_results[$];
        t_renamed   uncommitted[$];
        int         errors;
        bit         perfect_mem;
        logic [5:0] spec_map[32];
        logic [5:0] com_map[32];
        logic [5:0] ring[64];
        logic [6:0] spec_head;
        logic [6:0] com_head;
        logic [6:0] tail;
        logic [7:0] credits[4];

        function new();
            errors = 0;
            perfect_mem = 0;
            for (int i = 0; i < 32; i++) begin
                spec_map[i] = '0;
                com_map[i] = '0;
            end
            for (int i = 0; i < 64; i++) begin
                ring[i] = (i < 63) ? 6'(i + 1) : 6'd0;
            end
            spec_head = '0;
            com_head = '0;
            tail = 7'd63;
            for (int i = 0; i < 4; i++) begin
                credits[i] = '0;
            end
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        // Works out the result of one accepted item and advances the local state.
        function void note(t_in it);
            t_out       r;
            t_renamed   rec;
            logic [5:0] fresh;
            logic [8:0] sum;
            bit         is_load;
            bit         is_store;
            r = '0;
            is_load = (it.unit_kind == UK_LOAD);
            is_store = (it.unit_kind == UK_STORE);
            case (it.action)
                ACT_RENAME: begin
                    if (credits[CK_DISPATCH] == 0 || credits[CK_ROB] == 0) begin
                        r.stall_cause = STALL_CREDIT;
                    end else if (!perfect_mem && is_load && credits[CK_LOAD] == 0) begin
                        r.stall_cause = STALL_LOAD;
                    end else if (!perfect_mem && is_store && credits[CK_STORE] == 0) begin
                        r.stall_cause = STALL_STORE;
                    end else if (it.dest_valid && 7'(tail - spec_head) == 0) begin
                        r.stall_cause = STALL_FREE;
                    end
                    if (r.stall_cause == STALL_NONE) begin
                        r.accepted = 1'b1;
                        r.src1_phys = spec_map[it.src1_arch];
                        r.src2_phys = spec_map[it.src2_arch];
                        if (it.dest_valid) begin
                            fresh = ring[spec_head[5:0]];
                            r.old_phys = spec_map[it.dest_arch];
                            r.dest_phys = fresh;
                            rec.arch = it.dest_arch;
                            rec.new_phys = fresh;
                            rec.old_phys = r.old_phys;
                            uncommitted = {uncommitted, rec};
                            spec_map[it.dest_arch] = fresh;
                            spec_head = spec_head + 7'd1;
                        end
                        credits[CK_DISPATCH]--;
                        credits[CK_ROB]--;
                        if (!perfect_mem) begin
                            if (is_load) begin
                                credits[CK_LOAD]--;
                            end else if (is_store) begin
                                credits[CK_STORE]--;
                            end
                            r.to_memory_unit = is_load || is_store;
                        end
                    end
                end
                ACT_COMMIT: begin
                    if (it.commit_new_phys != 0) begin
                        if (com_head != spec_head) begin
                            com_head = com_head + 7'd1;
                        end
                        com_map[it.dest_arch] = it.commit_new_phys;
                    end
                    if (it.commit_old_phys != 0 && 7'(tail - com_head) < 7'd64) begin
                        ring[tail[5:0]] = it.commit_old_phys;
                        tail = tail + 7'd1;
                    end
                end
                ACT_FLUSH: begin
                    spec_map = com_map;
                    spec_head = com_head;
                    for (int i = 0; i < 4; i++) begin
                        credits[i] = '0;
                    end
                    uncommitted.delete();
                end
                default: begin
                    sum = {1'b0, credits[it.credit_kind]} + {2'b0, it.credit_amount};
                    credits[it.credit_kind] = (sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : sum[7:0];
                end
            endcase
            expected_results = {expected_results, r};
        endfunction

        task check(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                report("unexpected result, accepted", 8'(got.accepted), 8'd0);
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
            if (got.src1_phys !== want.src1_phys) report("src1_phys", got.src1_phys, want.src1_phys);
            if (got.src2_phys !== want.src2_phys) report("src2_phys", got.src2_phys, want.src2_phys);
            if (got.dest_phys !== want.dest_phys) report("dest_phys", got.dest_phys, want.dest_phys);
            if (got.old_phys !== want.old_phys) report("old_phys", got.old_phys, want.old_phys);
            if (got.to_memory_unit !== want.to_memory_unit) begin
                report("to_memory_unit", got.to_memory_unit, want.to_memory_unit);
            end
            if (got.stall_cause !== want.stall_cause) begin
                report("stall_cause", got.stall_cause, want.stall_cause);
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    t_out o_result;
    logic o_strobe;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    bit   idle_on = 1'b1;

    rename_scoreboard sb = new();

    register_rename_free_list dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_result(o_result),
        .o_strobe(o_strobe),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check(o_result);
        end
    end

    task automatic send_item(input t_in it);
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(it);
        if (idle_on && $urandom_range(99) < 38) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit mode);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.perfect_mem = mode;
    endtask

    function automatic t_in rand_fields();
        t_in it;
        it.action = 2'($urandom_range(0, 3));
        it.src1_arch = 5'($urandom_range(0, 31));
        it.src2_arch = 5'($urandom_range(0, 31));
        it.dest_arch = 5'($urandom_range(0, 31));
        it.dest_valid = 1'($urandom_range(0, 1));
        it.unit_kind = 2'($urandom_range(0, 3));
        it.commit_new_phys = 6'($urandom_range(0, 63));
        it.commit_old_phys = 6'($urandom_range(0, 63));
        it.credit_kind = 2'($urandom_range(0, 3));
        it.credit_amount = 7'($urandom_range(0, 64));
        return it;
    endfunction

    // Mostly well-formed traffic: credits, renames and in-order commits of
    // earlier renames, with occasional flushes and fully random items.
    function automatic t_in next_item();
        t_in      it;
        t_renamed rec;
        int       pick;
        it = rand_fields();
        pick = $urandom_range(99);
        if (pick < 25) begin
            it.action = ACT_CREDIT;
        end else if (pick < 70) begin
            it.action = ACT_RENAME;
            it.dest_valid = ($urandom_range(9) != 0);
        end else if (pick < 92) begin
            it.action = ACT_COMMIT;
            if (sb.uncommitted.size() > 0) begin
                rec = sb.uncommitted[0];
                sb.uncommitted.delete(0);
                it.dest_arch = rec.arch;
                it.commit_new_phys = rec.new_phys;
                it.commit_old_phys = rec.old_phys;
            end
        end else if (pick < 94) begin
            it.action = ACT_FLUSH;
        end
        return it;
    endfunction

    function automatic t_in mk(input t_action act, input logic [1:0] kind,
                               input logic [6:0] amount);
        t_in it;
        it = '0;
        it.action = act;
        it.credit_kind = kind;
        it.credit_amount = amount;
        return it;
    endfunction

    initial begin
        t_in it;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block runs a clearing pass after reset before it takes items.
        do @(posedge i_clk); while (busy);
        write_mode(1'b0);

        // Rename with no credit at all.
        it = mk(ACT_RENAME, CK_DISPATCH, 7'd0);
        it.dest_valid = 1'b1;
        send_item(it);
        send_item(mk(ACT_CREDIT, CK_DISPATCH, 7'd64));
        send_item(mk(ACT_CREDIT, CK_ROB, 7'd0));
        send_item(mk(ACT_CREDIT, CK_ROB, 7'd64));
        // Load and store without queue credit.
        it = mk(ACT_RENAME, CK_DISPATCH, 7'd0);
        it.unit_kind = UK_LOAD;
        send_item(it);
        it.unit_kind = UK_STORE;
        send_item(it);
        for (int i = 0; i < 5; i++) send_item(mk(ACT_CREDIT, CK_LOAD, 7'd64));
        for (int i = 0; i < 5; i++) send_item(mk(ACT_CREDIT, CK_STORE, 7'd64));
        it = '1;
        it.action = ACT_RENAME;
        it.unit_kind = UK_LOAD;
        send_item(it);
        it.unit_kind = UK_STORE;
        it.src1_arch = '0;
        send_item(it);
        it.unit_kind = 2'd3;
        it.dest_valid = 1'b0;
        send_item(it);
        it = '1;
        it.action = ACT_COMMIT;
        it.commit_new_phys = '0;
        send_item(it);
        it.commit_new_phys = 6'd1;
        it.commit_old_phys = 6'd0;
        send_item(it);
        send_item(mk(ACT_FLUSH, CK_DISPATCH, 7'd0));

        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) write_mode(phase[0]);
            for (int n = 0; n < 325; n++) begin
                idle_on = !(phase == 1 && n >= 100 && n < 200);
                if ($urandom_range(99) < 6) begin
                    send_item(rand_fields());
                end else begin
                    send_item(next_item());
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.expected_results.size() > 0) begin
            sb.report("results still outstanding", 8'(sb.expected_results.size()), 8'd0);
        end
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/rrf_pkg.sv
hdl/rrf_ram.sv
hdl/rrf_ctrl.sv
hdl/rrf_dp.sv
hdl/register_rename_free_list.sv
tb/tb_register_rename_free_list.sv
